// ===== design/fbrop_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame buffer pixel raster operation: shared definitions
// Types and constants used by the top level and by the pixel arithmetic unit.
// ----------------------------------------------------------------------------
package fbrop_pkg;

   // Request kinds carried in the request tuser field
   localparam logic [1:0] REQ_DRAW = 2'd0;
   localparam logic [1:0] REQ_READ = 2'd1;
   localparam logic [1:0] REQ_FILL = 2'd2;

   // Register indexes on the configuration channel
   localparam logic [2:0] CSR_DRAW_MODE = 3'd0;
   localparam logic [2:0] CSR_CLIP_X_LO = 3'd1;
   localparam logic [2:0] CSR_CLIP_X_HI = 3'd2;
   localparam logic [2:0] CSR_CLIP_Y_LO = 3'd3;
   localparam logic [2:0] CSR_CLIP_Y_HI = 3'd4;

   // Reciprocal of 255 scaled by 2^25; exact floor for dividends below 132626
   localparam logic [17:0] BLEND_RECIP = 18'd131587;
   localparam int          BLEND_SHIFT = 25;

   // Rounding offset of the invert blend product
   localparam logic [16:0] BLEND_ROUND = 17'd127;

   typedef enum logic [1:0] {
      MODE_SET,
      MODE_ADD,
      MODE_SUB,
      MODE_INVERT
   } draw_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_BLEND,
      ST_FILL
   } fsm_state_type;

   // Per-pixel control handed to the arithmetic unit
   typedef struct packed {
      draw_mode_type mode;
      logic          x_odd;
      logic [2:0]    row;
   } pix_ctl_type;

endpackage

// ===== design/framebuffer_pixel_rop.sv =====
// ----------------------------------------------------------------------------
// Frame buffer pixel raster operation with clip rectangle
// Draws, reads and fills pixels in a packed byte memory at 1, 4 or 8 bits per
// pixel, with a configurable draw mode and clip rectangle.
// ----------------------------------------------------------------------------
// Sequencing: all work goes through one single-port byte memory with a
// registered read port, one request at a time. For a draw or a read the accept
// cycle issues the memory read and the next cycle modifies and writes back or
// loads the result register. A draw outside the screen or the clip rectangle,
// and an unknown request, take only the accept cycle. The eight-bit invert
// blend adds a blend state after the update, because the division by 255 runs
// in a second multiply stage. A fill writes one byte per cycle from the first
// address to the last. A read waits in its update cycle while the previous
// result has not been taken. The memory has no reset and no clearing pass:
// pixels must be written, by a fill or a draw, before they are read.
// ----------------------------------------------------------------------------
module framebuffer_pixel_rop
   import fbrop_pkg::*;
#(
   parameter int SCREEN_WIDTH   = 128,
   parameter int SCREEN_HEIGHT  = 64,
   parameter int BITS_PER_PIXEL = 1
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // pixel_x[15:0], pixel_y[31:16], shade[39:32]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // read_shade[7:0]
   // Configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int STRIDE4   = (SCREEN_WIDTH + 1) / 2;
   localparam int MEM_BYTES = (BITS_PER_PIXEL == 1) ?
                              SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8) :
                              ((BITS_PER_PIXEL == 4) ? STRIDE4 * SCREEN_HEIGHT :
                                                       SCREEN_WIDTH * SCREEN_HEIGHT);
   localparam int AW        = $clog2(MEM_BYTES);
   localparam int XW        = $clog2(SCREEN_WIDTH);
   localparam int YW        = $clog2(SCREEN_HEIGHT);
   localparam bit BYTE_MODE = (BITS_PER_PIXEL != 1) && (BITS_PER_PIXEL != 4);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);

   // Request fields
   logic [15:0] pixel_x;
   logic [15:0] pixel_y;
   logic [7:0]  shade;
   logic [1:0]  req_type;
   logic        req_xfer;

   assign pixel_x  = req_tdata[15:0];
   assign pixel_y  = req_tdata[31:16];
   assign shade    = req_tdata[39:32];
   assign req_type = req_tuser;
   assign req_xfer = req_tvalid && req_tready;

   // Configuration registers
   draw_mode_type draw_mode_ff;
   logic [7:0]    clip_x_lo_ff;
   logic [7:0]    clip_x_hi_ff;
   logic [6:0]    clip_y_lo_ff;
   logic [6:0]    clip_y_hi_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_mode_ff <= MODE_SET;
         clip_x_lo_ff <= 8'd0;
         clip_x_hi_ff <= 8'(SCREEN_WIDTH);
         clip_y_lo_ff <= 7'd0;
         clip_y_hi_ff <= 7'(SCREEN_HEIGHT);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DRAW_MODE: draw_mode_ff <= draw_mode_type'(csr_wdata[1:0]);
            CSR_CLIP_X_LO: clip_x_lo_ff <= csr_wdata;
            CSR_CLIP_X_HI: clip_x_hi_ff <= csr_wdata;
            CSR_CLIP_Y_LO: clip_y_lo_ff <= csr_wdata[6:0];
            CSR_CLIP_Y_HI: clip_y_hi_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // Screen and clip tests on the incoming coordinates
   logic on_screen;
   logic in_clip;

   assign on_screen = !pixel_x[15] && !pixel_y[15] &&
                      (pixel_x < 16'(SCREEN_WIDTH)) && (pixel_y < 16'(SCREEN_HEIGHT));
   assign in_clip   = (pixel_x >= {8'd0, clip_x_lo_ff}) && (pixel_x < {8'd0, clip_x_hi_ff}) &&
                      (pixel_y >= {9'd0, clip_y_lo_ff}) && (pixel_y < {9'd0, clip_y_hi_ff});

   // Byte address of the pixel, meaningful only on screen
   logic [XW-1:0] x_idx;
   logic [YW-1:0] y_idx;
   logic [AW-1:0] pix_addr;

   assign x_idx = pixel_x[XW-1:0];
   assign y_idx = pixel_y[YW-1:0];

   always_comb begin
      if (BITS_PER_PIXEL == 1) begin
         pix_addr = AW'(x_idx) + AW'(y_idx >> 3) * AW'(SCREEN_WIDTH);
      end else if (BITS_PER_PIXEL == 4) begin
         pix_addr = AW'(x_idx >> 1) + AW'(y_idx) * AW'(STRIDE4);
      end else begin
         pix_addr = AW'(x_idx) + AW'(y_idx) * AW'(SCREEN_WIDTH);
      end
   end

   // Control and request holding registers
   fsm_state_type state_ff, state_in;
   logic [1:0]    kind_ff;
   logic          on_screen_ff;
   logic [AW-1:0] addr_ff;
   logic          x_odd_ff;
   logic [2:0]    row_ff;
   logic [7:0]    shade_ff;
   logic [AW-1:0] fill_addr_ff, fill_addr_in;
   logic [16:0]   prod_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_data_ff;

   // Memory side
   logic [7:0]    pixel_mem [MEM_BYTES];
   logic [7:0]    rd_data_ff;
   logic          mem_rd;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic [7:0]    fill_byte;
   logic          rsp_load;
   logic          blend8;

   // Arithmetic unit
   pix_ctl_type pix_ctl;
   logic [7:0]  alu_new_byte;
   logic [7:0]  alu_read_shade;
   logic [16:0] alu_blend_prod;
   logic [7:0]  alu_blend_byte;

   assign pix_ctl = '{mode: draw_mode_ff, x_odd: x_odd_ff, row: row_ff};

   fbrop_pixel_alu #(
      .BITS_PER_PIXEL (BITS_PER_PIXEL)
   ) u_alu (
      .ctl           (pix_ctl),
      .shade         (shade_ff),
      .old_byte      (rd_data_ff),
      .blend_prod_ff (prod_ff),
      .new_byte      (alu_new_byte),
      .read_shade    (alu_read_shade),
      .blend_prod    (alu_blend_prod),
      .blend_byte    (alu_blend_byte)
   );

   assign blend8 = BYTE_MODE && (draw_mode_ff == MODE_INVERT);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_type)
                  REQ_DRAW: state_in = (on_screen && in_clip) ? ST_UPDATE : ST_IDLE;
                  REQ_READ: state_in = ST_UPDATE;
                  REQ_FILL: state_in = ST_FILL;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_UPDATE: begin
            if (kind_ff == REQ_READ) begin
               state_in = (!rsp_valid_ff || rsp_tready) ? ST_IDLE : ST_UPDATE;
            end else begin
               state_in = blend8 ? ST_BLEND : ST_IDLE;
            end
         end
         ST_BLEND: state_in = ST_IDLE;
         ST_FILL:  state_in = (fill_addr_ff == LAST_ADDR) ? ST_IDLE : ST_FILL;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      mem_rd       = (state_ff == ST_IDLE) && req_xfer && on_screen;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = alu_new_byte;
      rsp_load     = 1'b0;
      fill_addr_in = fill_addr_ff;
      case (state_ff)
         ST_IDLE: begin
            fill_addr_in = '0;
         end
         ST_UPDATE: begin
            if (kind_ff == REQ_READ) begin
               rsp_load = !rsp_valid_ff || rsp_tready;
            end else begin
               mem_we = !blend8;
            end
         end
         ST_BLEND: begin
            mem_we    = 1'b1;
            mem_wdata = alu_blend_byte;
         end
         ST_FILL: begin
            mem_we       = 1'b1;
            mem_waddr    = fill_addr_ff;
            mem_wdata    = fill_byte;
            fill_addr_in = fill_addr_ff + AW'(1);
         end
         default: ;
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   // Fill byte: the shade quantised to the pixel depth
   always_comb begin
      if (BITS_PER_PIXEL == 1) begin
         fill_byte = shade_ff[7] ? 8'hFF : 8'h00;
      end else if (BITS_PER_PIXEL == 4) begin
         fill_byte = {shade_ff[7:4], shade_ff[7:4]};
      end else begin
         fill_byte = shade_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fill_addr_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_addr_ff <= fill_addr_in;
      end
   end

   // Request holding registers, loaded on each accepted transfer, and the blend product and result registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         kind_ff      <= req_type;
         on_screen_ff <= on_screen;
         addr_ff      <= pix_addr;
         x_odd_ff     <= pixel_x[0];
         row_ff       <= pixel_y[2:0];
         shade_ff     <= shade;
      end
      if (state_ff == ST_UPDATE) begin
         prod_ff <= alu_blend_prod;
      end
      if (rsp_load) begin
         rsp_data_ff <= on_screen_ff ? alu_read_shade : 8'h00;
      end
   end

   // Pixel memory. The write of one request lands before the next request's
   // read is issued, so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pixel_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_rd) begin
         rd_data_ff <= pixel_mem[pix_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A fill leaves the fill state right after its last byte
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL && fill_addr_ff == LAST_ADDR) |=> (state_ff == ST_IDLE))
      else $error("fill did not end after the last byte");

   // The memory is never written while requests are being accepted
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff != ST_IDLE))
      else $error("memory write while idle");

   // A result only appears from the update cycle of a read
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_UPDATE && kind_ff == REQ_READ))
      else $error("result raised outside a read update");

   // The blend stage only follows a draw update
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BLEND) |-> ($past(state_ff) == ST_UPDATE && kind_ff == REQ_DRAW))
      else $error("blend stage entered without a draw");

endmodule

// ===== design/fbrop_pixel_alu.sv =====
// ----------------------------------------------------------------------------
// Frame buffer pixel arithmetic unit
// Merges a shade into a stored byte at the configured depth, expands a stored
// pixel to eight bits and finishes the eight-bit invert blend.
// ----------------------------------------------------------------------------
module fbrop_pixel_alu
   import fbrop_pkg::*;
#(
   parameter int BITS_PER_PIXEL = 1
) (
   input  pix_ctl_type ctl,
   input  logic [7:0]  shade,
   input  logic [7:0]  old_byte,
   input  logic [16:0] blend_prod_ff,
   output logic [7:0]  new_byte,
   output logic [7:0]  read_shade,
   output logic [16:0] blend_prod,
   output logic [7:0]  blend_byte
);

   logic [7:0]  bit_mask;
   logic        shade_on;
   logic [3:0]  nib;
   logic [3:0]  shade_nib;
   logic [4:0]  nib_sum;
   logic [3:0]  nib_new;
   logic [7:0]  nib_wide;
   logic [16:0] nib_prod;
   logic [9:0]  nib_blend;
   logic [8:0]  byte_sum;
   logic [34:0] quot_full;
   logic [8:0]  quot;
   logic [9:0]  byte_blend;

   function automatic logic [15:0] old_byte_sel_prod(input logic [7:0] a, input logic [7:0] b);
      return 16'(a) * 16'(b);
   endfunction

   assign bit_mask  = 8'(1) << ctl.row;
   assign shade_on  = shade[7];
   assign nib       = ctl.x_odd ? old_byte[3:0] : old_byte[7:4];
   assign shade_nib = shade[7:4];
   assign nib_sum   = {1'b0, nib} + {1'b0, shade_nib};
   assign nib_wide  = {nib, nib};
   assign byte_sum  = {1'b0, old_byte} + {1'b0, shade};

   // Half-byte invert blend: replicated nibble, product rounded by a shift
   assign nib_prod  = {old_byte_sel_prod(nib_wide, shade), 1'b0} + BLEND_ROUND;
   assign nib_blend = {2'b00, nib_wide} + {2'b00, shade} - {1'b0, nib_prod[16:8]};

   // Eight-bit invert blend, first stage: twice the product plus rounding
   assign blend_prod = {old_byte_sel_prod(old_byte, shade), 1'b0} + BLEND_ROUND;

   // Second stage: divide the registered product by 255 through the reciprocal
   assign quot_full  = 35'(blend_prod_ff) * 35'(BLEND_RECIP);
   assign quot       = quot_full[BLEND_SHIFT +: 9];
   assign byte_blend = {2'b00, old_byte} + {2'b00, shade} - {1'b0, quot};
   assign blend_byte = byte_blend[7:0];

   // New nibble value at four bits per pixel
   always_comb begin
      case (ctl.mode)
         MODE_SET:    nib_new = shade_nib;
         MODE_ADD:    nib_new = nib_sum[4] ? 4'hF : nib_sum[3:0];
         MODE_SUB:    nib_new = (nib > shade_nib) ? (nib - shade_nib) : 4'h0;
         MODE_INVERT: nib_new = nib_blend[7:4];
         default:     nib_new = nib;
      endcase
   end

   // Merged byte for every depth; the invert blend at eight bits uses blend_byte
   always_comb begin
      if (BITS_PER_PIXEL == 1) begin
         case (ctl.mode)
            MODE_SET:    new_byte = shade_on ? (old_byte | bit_mask) : (old_byte & ~bit_mask);
            MODE_ADD:    new_byte = shade_on ? (old_byte | bit_mask) : old_byte;
            MODE_SUB:    new_byte = shade_on ? (old_byte & ~bit_mask) : old_byte;
            MODE_INVERT: new_byte = shade_on ? (old_byte ^ bit_mask) : old_byte;
            default:     new_byte = old_byte;
         endcase
      end else if (BITS_PER_PIXEL == 4) begin
         new_byte = ctl.x_odd ? {old_byte[7:4], nib_new} : {nib_new, old_byte[3:0]};
      end else begin
         case (ctl.mode)
            MODE_SET:    new_byte = shade;
            MODE_ADD:    new_byte = byte_sum[8] ? 8'hFF : byte_sum[7:0];
            MODE_SUB:    new_byte = (old_byte > shade) ? (old_byte - shade) : 8'h00;
            MODE_INVERT: new_byte = blend_byte;
            default:     new_byte = old_byte;
         endcase
      end
   end

   // Expansion of a stored pixel to eight bits
   always_comb begin
      if (BITS_PER_PIXEL == 1) begin
         read_shade = old_byte[ctl.row] ? 8'hFF : 8'h00;
      end else if (BITS_PER_PIXEL == 4) begin
         read_shade = nib_wide;
      end else begin
         read_shade = old_byte;
      end
   end

endmodule
